/* rtl/core/rr_pkg.sv */
`default_nettype none

package rr_pkg;

    // Width of one fraction part.
    localparam int DATA_WIDTH = 32;

    // Stream data width: both parts packed, padded to whole bytes.
    localparam int TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8;

    // Width of the divider bit counter.
    localparam int CNT_W = $clog2(DATA_WIDTH);

    // Divider operand selection.
    localparam logic [1:0] DIV_EUC = 2'd0;  // a % b for one Euclid step
    localparam logic [1:0] DIV_NUM = 2'd1;  // |numerator| / gcd
    localparam logic [1:0] DIV_DEN = 2'd2;  // |denominator| / gcd

    typedef logic [DATA_WIDTH-1:0] word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       div_start;
        logic [1:0] div_sel;
        logic       euc_step;
        logic       qn_save;
        logic       out_load;
    } rr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic b_zero;
        logic inv;
        logic div_done;
    } rr_sts_t;

endpackage

`default_nettype wire

/* rtl/core/rr_divider.sv */
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module rr_divider
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire rr_pkg::word_t  dividend,
    input  wire rr_pkg::word_t  divisor,
    output rr_pkg::word_t       quotient,
    output rr_pkg::word_t       remainder,
    output logic                done
);

    rr_pkg::word_t                 rem_reg, rem_next;
    rr_pkg::word_t                 quo_reg, quo_next;
    rr_pkg::word_t                 dvs_reg, dvs_next;
    logic [rr_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [rr_pkg::DATA_WIDTH:0]   shifted;
    logic [rr_pkg::DATA_WIDTH:0]   trial;
    logic                          borrow;

    // Trial subtraction of the divisor from the shifted partial remainder.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[rr_pkg::DATA_WIDTH-1]};
        trial   = shifted - {1'b0, dvs_reg};
        borrow  = trial[rr_pkg::DATA_WIDTH];
    end

    // Next-state logic for one iteration.
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = rr_pkg::CNT_W'(rr_pkg::DATA_WIDTH - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = borrow ? shifted[rr_pkg::DATA_WIDTH-1:0]
                              : trial[rr_pkg::DATA_WIDTH-1:0];
            quo_next = {quo_reg[rr_pkg::DATA_WIDTH-2:0], ~borrow};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operand and result registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

/* rtl/core/rr_datapath.sv */
`default_nettype none

// Operand registers, Euclid pair, shared divider and result register.
module rr_datapath
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire rr_pkg::rr_cmd_t        cmd,
    output rr_pkg::rr_sts_t             sts,
    input  wire rr_pkg::word_t          numerator,
    input  wire rr_pkg::word_t          denominator,
    output rr_pkg::word_t               reduced_numerator,
    output rr_pkg::word_t               reduced_denominator,
    output logic                        invalid
);

    rr_pkg::word_t n_reg;
    rr_pkg::word_t nm_reg, dm_reg;
    rr_pkg::word_t a_reg, b_reg;
    rr_pkg::word_t qn_reg;
    logic          neg_reg;
    logic          inv_reg;
    rr_pkg::word_t num_out_reg, den_out_reg;
    logic          inv_out_reg;

    rr_pkg::word_t nm_in, dm_in;
    rr_pkg::word_t div_dividend, div_divisor;
    rr_pkg::word_t div_quo, div_rem;
    logic          div_done;

    // Magnitudes of the incoming parts, as unsigned values.
    always_comb
    begin
        nm_in = numerator[rr_pkg::DATA_WIDTH-1] ? (~numerator + 1'b1) : numerator;
        dm_in = denominator[rr_pkg::DATA_WIDTH-1] ? (~denominator + 1'b1) : denominator;
    end

    // Divider operand selection.
    always_comb
    begin
        case (cmd.div_sel)
            rr_pkg::DIV_EUC:
            begin
                div_dividend = a_reg;
                div_divisor  = b_reg;
            end
            rr_pkg::DIV_NUM:
            begin
                div_dividend = nm_reg;
                div_divisor  = a_reg;
            end
            rr_pkg::DIV_DEN:
            begin
                div_dividend = dm_reg;
                div_divisor  = a_reg;
            end
            default:
            begin
                div_dividend = a_reg;
                div_divisor  = b_reg;
            end
        endcase
    end

    rr_divider u_rr_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    // Operand capture and the Euclid pair.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg   <= numerator;
            nm_reg  <= nm_in;
            dm_reg  <= dm_in;
            a_reg   <= nm_in;
            b_reg   <= dm_in;
            neg_reg <= (nm_in != '0) &&
                       (numerator[rr_pkg::DATA_WIDTH-1] != denominator[rr_pkg::DATA_WIDTH-1]);
            inv_reg <= (denominator == '0);
        end
        else if (cmd.euc_step)
        begin
            a_reg <= b_reg;
            b_reg <= div_rem;
        end
        if (cmd.qn_save)
        begin
            qn_reg <= div_quo;
        end
    end

    // Result register; the denominator quotient is still in the divider.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (inv_reg)
            begin
                num_out_reg <= n_reg;
                den_out_reg <= '0;
                inv_out_reg <= 1'b1;
            end
            else
            begin
                num_out_reg <= neg_reg ? (~qn_reg + 1'b1) : qn_reg;
                den_out_reg <= div_quo;
                inv_out_reg <= 1'b0;
            end
        end
    end

    assign sts.b_zero   = (b_reg == '0);
    assign sts.inv      = inv_reg;
    assign sts.div_done = div_done;

    assign reduced_numerator   = num_out_reg;
    assign reduced_denominator = den_out_reg;
    assign invalid             = inv_out_reg;

endmodule

`default_nettype wire

/* rtl/core/rr_ctrl.sv */
`default_nettype none

// Sequencer: Euclid loop, two quotient divisions, result hand-off.
module rr_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire rr_pkg::rr_sts_t    sts,
    output rr_pkg::rr_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_EUC      = 3'd1;
    localparam logic [2:0] ST_EUC_WAIT = 3'd2;
    localparam logic [2:0] ST_QN_WAIT  = 3'd3;
    localparam logic [2:0] ST_QD_WAIT  = 3'd4;
    localparam logic [2:0] ST_FINISH   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    // The result register can be refilled when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;

    // State transitions and commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.div_sel = rr_pkg::DIV_EUC;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EUC;
                end
            end
            ST_EUC:
            begin
                if (sts.inv)
                begin
                    state_next = ST_FINISH;
                end
                else if (sts.b_zero)
                begin
                    // The gcd sits in a; divide the numerator magnitude by it.
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = rr_pkg::DIV_NUM;
                    state_next    = ST_QN_WAIT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = rr_pkg::DIV_EUC;
                    state_next    = ST_EUC_WAIT;
                end
            end
            ST_EUC_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.euc_step = 1'b1;
                    state_next   = ST_EUC;
                end
            end
            ST_QN_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.qn_save   = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = rr_pkg::DIV_DEN;
                    state_next    = ST_QD_WAIT;
                end
            end
            ST_QD_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag.
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/core/rational_reduce_top.sv */
// Channel   Direction  Beat contents
// s_        in         tdata: numerator, denominator
// m_        out        tdata: reduced_numerator, reduced_denominator; tuser: invalid
//
// One fraction is in flight at a time. Each remainder or quotient comes from
// one shared restoring divider at one bit per cycle; an invalid fraction
// skips the divider. Reset clears only control state. A new beat is taken
// while a result waits on m_.
`default_nettype none

module rational_reduce_top
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // numerator [DW-1:0], denominator [2*DW-1:DW], zero padding above
    input  wire logic [rr_pkg::TDATA_W-1:0] s_tdata,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // reduced_numerator [DW-1:0], reduced_denominator [2*DW-1:DW], zero padding above
    output logic [rr_pkg::TDATA_W-1:0]      m_tdata,
    // invalid
    output logic                            m_tuser,
    output logic                            m_tvalid,
    input  wire logic                       m_tready
);

    rr_pkg::rr_cmd_t cmd;
    rr_pkg::rr_sts_t sts;
    rr_pkg::word_t   red_num, red_den;

    rr_ctrl u_rr_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rr_datapath u_rr_datapath
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .sts                 (sts),
        .numerator           (s_tdata[rr_pkg::DATA_WIDTH-1:0]),
        .denominator         (s_tdata[2*rr_pkg::DATA_WIDTH-1:rr_pkg::DATA_WIDTH]),
        .reduced_numerator   (red_num),
        .reduced_denominator (red_den),
        .invalid             (m_tuser)
    );

    // Pack the result parts, zero-padded to whole bytes.
    assign m_tdata = rr_pkg::TDATA_W'({red_den, red_num});

endmodule

`default_nettype wire

/* rtl/core/rr_checker.sv */
`default_nettype none

// Port-level checks on the fraction reducer.
module rr_checker
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    input  wire logic                       s_tready,
    input  wire logic [rr_pkg::TDATA_W-1:0] m_tdata,
    input  wire logic                       m_tuser,
    input  wire logic                       m_tvalid,
    input  wire logic                       m_tready
);

    // An invalid result always carries a zero denominator.
    a_inv_den_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |->
            m_tdata[2*rr_pkg::DATA_WIDTH-1:rr_pkg::DATA_WIDTH] == '0)
        else $error("invalid result with nonzero denominator");

    // A valid result never has a zero denominator.
    a_valid_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |->
            m_tdata[2*rr_pkg::DATA_WIDTH-1:rr_pkg::DATA_WIDTH] != '0)
        else $error("valid result with zero denominator");

    // The input side closes only after taking a beat.
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("s_tready dropped without an accepted beat");

    // A stalled result stays presented and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed or was withdrawn");

endmodule

bind rational_reduce_top rr_checker u_rr_checker (.*);

`default_nettype wire
